// ----- design/sfcp_pkg.sv -----
// Package for the serial frame capture parser: shared types and byte codes.
// Depends on nothing; used by the core, the output stage and the checker.
package sfcp_pkg;

  // Byte codes of the receive envelope.
  localparam logic [7:0] EnvSync = 8'h55;
  localparam logic [7:0] EnvHead = 8'hAA;

  // Byte codes of the transmit escape sequences.
  localparam logic [7:0] ChEscape   = 8'h21;  // '!'
  localparam logic [7:0] ChLiteral  = 8'h2E;  // '.'
  localparam logic [7:0] ChClearLow = 8'h63;  // 'c'
  localparam logic [7:0] ChClearUp  = 8'h43;  // 'C'

  // Direction codes on the result channel.
  localparam logic DirRx = 1'b0;
  localparam logic DirTx = 1'b1;

  // Most results that one packet produces.
  localparam int MaxResults = 64;

  typedef enum logic {
    StIdle,
    StDrain
  } state_e;

  // Description of one result whose payload byte is being read.
  typedef struct packed {
    logic        dir;
    logic [5:0]  idx;
    logic        empty;
    logic        last;
    logic [15:0] num;
  } meta_t;

endpackage

// ----- design/sfcp_out_stage.sv -----
// Read stage and output register of the packet drain path.
// Depends on sfcp_pkg for the result description type.
module sfcp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          issue_i,
  input  sfcp_pkg::meta_t meta_i,
  input  logic [7:0]    rd_data_i,
  output logic          can_issue_o,
  output logic          pend_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          direction_o,
  output logic [7:0]    data_byte_o,
  output logic [5:0]    byte_index_o,
  output logic          empty_packet_o,
  output logic          last_byte_o,
  output logic [15:0]   packet_number_o
);

  logic            pend_q, pend_d;
  sfcp_pkg::meta_t pend_meta_q;
  logic            out_valid_q, out_valid_d;
  logic            load;

  // The read data register holds until the next issue, so a stalled result
  // simply waits in the read stage.
  assign load        = pend_q && (!out_valid_q || out_ready_i);
  assign can_issue_o = !pend_q || load;
  assign pend_o      = pend_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    pend_d = pend_q;
    if (issue_i) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      pend_meta_q <= meta_i;
    end
    if (load) begin
      direction_o     <= pend_meta_q.dir;
      data_byte_o     <= pend_meta_q.empty ? 8'h00 : rd_data_i;
      byte_index_o    <= pend_meta_q.idx;
      empty_packet_o  <= pend_meta_q.empty;
      last_byte_o     <= pend_meta_q.last;
      packet_number_o <= pend_meta_q.num;
    end
  end

endmodule

// ----- design/serial_frame_capture_parser_core.sv -----
// Top level of the serial frame capture parser; depends on sfcp_pkg and sfcp_out_stage.
// A byte that closes no packet leaves the core ready in the next cycle. A packet of n results
// (n = 1 when empty) comes out one result per cycle unless the output stalls, paced by the
// single read port of its memory; the next byte is taken once the last result has left the
// read stage. Reset clears the fill counts, pointers, escape flag and packet counters at once;
// the byte memories are not cleared and need no clearing pass.
module serial_frame_capture_parser_core #(
  parameter int RX_WINDOW_DEPTH = 64,
  parameter int TX_BUFFER_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        direction_o,
  output logic [7:0]  data_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        empty_packet_o,
  output logic        last_byte_o,
  output logic [15:0] packet_number_o
);

  localparam int RAW = $clog2(RX_WINDOW_DEPTH);
  localparam int RFW = $clog2(RX_WINDOW_DEPTH + 1);
  localparam int TAW = $clog2(TX_BUFFER_DEPTH);
  localparam int TFW = $clog2(TX_BUFFER_DEPTH + 1);
  localparam int OW  = (RAW > 9) ? RAW : 9;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  // The receive window is a circular buffer: wr_ptr_q is the next write
  // address, so the newest byte sits one entry below it. The last eight
  // bytes are also kept in a tap line so that the envelope can be checked
  // in the cycle a byte arrives.
  logic [7:0]     rx_mem [RX_WINDOW_DEPTH];
  logic [7:0]     tx_mem [TX_BUFFER_DEPTH];
  logic [7:0]     rx_rd_q, tx_rd_q;
  logic [7:0]     tap_q [8];
  logic [RAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RFW-1:0] rx_fill_q, rx_fill_d;
  logic [TFW-1:0] tx_fill_q, tx_fill_d;
  logic           esc_q, esc_d;
  logic [15:0]    rx_cnt_q, rx_cnt_d;
  logic [15:0]    tx_cnt_q, tx_cnt_d;

  // Drain sequencer registers.
  sfcp_pkg::state_e state_q, state_d;
  logic           drain_dir_q;
  logic [15:0]    drain_num_q;
  logic           drain_empty_q;
  logic [6:0]     drain_len_q;
  logic [6:0]     iss_cnt_q, iss_cnt_d;
  logic [RAW-1:0] off_q, off_d;

  // ---------------------------------------------------------------------
  // Parsing of an accepted byte
  // ---------------------------------------------------------------------
  logic           in_accept;
  logic           env_hit, rx_emit, tx_emit;
  logic [7:0]     rx_len;
  logic           tx_append, tx_wr, tx_clear;
  logic [7:0]     tx_wr_data;
  logic [6:0]     new_len;
  logic           new_empty;
  logic [OW-1:0]  off_full;

  assign in_accept = in_valid_i && in_ready_o;

  always_comb begin
    // The window saturates at its depth: the oldest byte is overwritten.
    rx_fill_d = rx_fill_q;
    wr_ptr_d  = wr_ptr_q;
    if (in_accept) begin
      if (rx_fill_q != RFW'(RX_WINDOW_DEPTH)) begin
        rx_fill_d = rx_fill_q + RFW'(1);
      end
      wr_ptr_d = (wr_ptr_q == RAW'(RX_WINDOW_DEPTH - 1)) ? '0 : wr_ptr_q + RAW'(1);
    end

    // Envelope: newest byte 0x55, seven back 0x55, eight back 0xAA; the
    // length sits three back. Taps are the bytes before the new one.
    rx_len  = tap_q[2];
    env_hit = (32'(rx_fill_d) >= 32'd9) && (in_byte_i == sfcp_pkg::EnvSync) &&
              (tap_q[6] == sfcp_pkg::EnvSync) && (tap_q[7] == sfcp_pkg::EnvHead);
    rx_emit = in_accept && env_hit && (32'(rx_len) + 32'd9 <= 32'(rx_fill_d));

    // Transmit unescaping.
    tx_emit   = in_accept && esc_q && (in_byte_i == sfcp_pkg::ChEscape);
    tx_append = (!esc_q && (in_byte_i != sfcp_pkg::ChEscape)) ||
                (esc_q && (in_byte_i == sfcp_pkg::ChLiteral));
    tx_wr_data = esc_q ? sfcp_pkg::ChEscape : in_byte_i;
    tx_wr     = in_accept && tx_append && (tx_fill_q < TFW'(TX_BUFFER_DEPTH));
    tx_clear  = in_accept && esc_q && ((in_byte_i == sfcp_pkg::ChEscape) ||
                (in_byte_i == sfcp_pkg::ChClearLow) || (in_byte_i == sfcp_pkg::ChClearUp));

    tx_fill_d = tx_fill_q;
    if (tx_clear) begin
      tx_fill_d = '0;
    end else if (tx_wr) begin
      tx_fill_d = tx_fill_q + TFW'(1);
    end

    esc_d = esc_q;
    if (in_accept) begin
      esc_d = !esc_q && (in_byte_i == sfcp_pkg::ChEscape);
    end

    rx_cnt_d = rx_emit ? rx_cnt_q + 16'd1 : rx_cnt_q;
    tx_cnt_d = tx_emit ? tx_cnt_q + 16'd1 : tx_cnt_q;

    // Packet length, clipped to the result limit; an empty packet still
    // produces one result.
    new_len = '0;
    if (rx_emit) begin
      new_len = (32'(rx_len) > 32'(sfcp_pkg::MaxResults)) ?
                7'(sfcp_pkg::MaxResults) : 7'(rx_len);
    end else begin
      new_len = (32'(tx_fill_q) > 32'(sfcp_pkg::MaxResults)) ?
                7'(sfcp_pkg::MaxResults) : 7'(tx_fill_q);
    end
    new_empty = (new_len == 7'd0);

    // Distance back from the newest byte to the first payload byte.
    off_full = OW'(rx_len) + OW'(8);
  end

  // ---------------------------------------------------------------------
  // Drain sequencer
  // ---------------------------------------------------------------------
  logic            can_issue, pend;
  logic            issue;
  logic            issue_last;
  sfcp_pkg::meta_t issue_meta;
  logic [RAW:0]    rx_sum;
  logic [RAW-1:0]  rx_rd_addr;
  logic [TAW-1:0]  tx_rd_addr;

  assign issue_last = (iss_cnt_q + 7'd1 == (drain_empty_q ? 7'd1 : drain_len_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfcp_pkg::StIdle: begin
        if (rx_emit || tx_emit) begin
          state_d = sfcp_pkg::StDrain;
        end
      end
      sfcp_pkg::StDrain: begin
        if (issue && issue_last) begin
          state_d = sfcp_pkg::StIdle;
        end
      end
      default: state_d = sfcp_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    case (state_q)
      sfcp_pkg::StIdle:  in_ready_o = !pend;
      sfcp_pkg::StDrain: issue      = can_issue;
      default: begin
        in_ready_o = 1'b0;
        issue      = 1'b0;
      end
    endcase
  end

  always_comb begin
    iss_cnt_d = iss_cnt_q;
    off_d     = off_q;
    if (in_accept) begin
      iss_cnt_d = '0;
      off_d     = off_full[RAW-1:0];
    end else if (issue) begin
      iss_cnt_d = iss_cnt_q + 7'd1;
      off_d     = off_q - RAW'(1);
    end

    issue_meta.dir   = drain_dir_q;
    issue_meta.idx   = iss_cnt_q[5:0];
    issue_meta.empty = drain_empty_q;
    issue_meta.last  = issue_last;
    issue_meta.num   = drain_num_q;

    // Newest byte is at wr_ptr_q - 1; step back by the offset, modulo depth.
    rx_sum = (RAW+1)'(wr_ptr_q) + (RAW+1)'(RX_WINDOW_DEPTH - 1) - (RAW+1)'(off_q);
    if (rx_sum >= (RAW+1)'(RX_WINDOW_DEPTH)) begin
      rx_sum = rx_sum - (RAW+1)'(RX_WINDOW_DEPTH);
    end
    rx_rd_addr = rx_sum[RAW-1:0];
    tx_rd_addr = TAW'(iss_cnt_q);
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfcp_pkg::StIdle;
      wr_ptr_q  <= '0;
      rx_fill_q <= '0;
      tx_fill_q <= '0;
      esc_q     <= 1'b0;
      rx_cnt_q  <= '0;
      tx_cnt_q  <= '0;
      iss_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      wr_ptr_q  <= wr_ptr_d;
      rx_fill_q <= rx_fill_d;
      tx_fill_q <= tx_fill_d;
      esc_q     <= esc_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_cnt_q  <= tx_cnt_d;
      iss_cnt_q <= iss_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    if (in_accept) begin
      tap_q[0] <= in_byte_i;
      for (int i = 1; i < 8; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
      drain_dir_q   <= rx_emit ? sfcp_pkg::DirRx : sfcp_pkg::DirTx;
      drain_num_q   <= rx_emit ? rx_cnt_q : tx_cnt_q;
      drain_len_q   <= new_len;
      drain_empty_q <= new_empty;
    end
  end

  // Receive window memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rx_mem[wr_ptr_q] <= in_byte_i;
    end
    if (issue && (drain_dir_q == sfcp_pkg::DirRx)) begin
      rx_rd_q <= rx_mem[rx_rd_addr];
    end
  end

  // Transmit buffer memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tx_wr) begin
      tx_mem[tx_fill_q[TAW-1:0]] <= tx_wr_data;
    end
    if (issue && (drain_dir_q == sfcp_pkg::DirTx)) begin
      tx_rd_q <= tx_mem[tx_rd_addr];
    end
  end

  sfcp_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .issue_i        (issue),
    .meta_i         (issue_meta),
    .rd_data_i      ((drain_dir_q == sfcp_pkg::DirRx) ? rx_rd_q : tx_rd_q),
    .can_issue_o    (can_issue),
    .pend_o         (pend),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .direction_o    (direction_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .empty_packet_o (empty_packet_o),
    .last_byte_o    (last_byte_o),
    .packet_number_o(packet_number_o)
  );

endmodule

// ----- design/sfcp_checker.sv -----
// Port-level checker for the serial frame capture parser, bound to the core.
// Depends on sfcp_pkg for the byte codes.
module sfcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        direction_o,
  input logic [7:0]  data_byte_o,
  input logic [5:0]  byte_index_o,
  input logic        empty_packet_o,
  input logic        last_byte_o,
  input logic [15:0] packet_number_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o) &&
      $stable(byte_index_o) && $stable(last_byte_o) && $stable(packet_number_o))
    else $error("stalled result changed");

  // An empty packet is a single result with a zero byte at index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_packet_o |-> last_byte_o && (byte_index_o == 6'd0) &&
      (data_byte_o == 8'h00))
    else $error("malformed empty packet");

  // No new byte is taken while a packet is still being delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_byte_o |-> !in_ready_o)
    else $error("input taken in the middle of a packet");

  // A byte that can close neither packet leaves the core ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_byte_i != sfcp_pkg::ChEscape) &&
      (in_byte_i != sfcp_pkg::EnvSync) |=> in_ready_o)
    else $error("core stalled after an ordinary byte");

endmodule

bind serial_frame_capture_parser_core sfcp_checker u_sfcp_checker (.*);
